>>> sv/ccl_pkg.sv
package ccl_pkg;

	localparam int CFG_W   = 9;
	localparam int OP_W    = 2;
	localparam int PIX_W   = 16;
	localparam int VAL_W   = 8;
	localparam int REG_W   = 14;
	localparam int CNT_W   = 15;
	localparam int COORD_W = 8;
	localparam int AREA_W  = 17;
	localparam int CIDX_W  = 1;

	localparam logic [CIDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CIDX_W-1:0] REG_COLS = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_RUN    = 2'd1,
		OP_LABEL  = 2'd2,
		OP_REGION = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RWAIT,
		ST_CLR,
		ST_SCAN_RD,
		ST_SCAN_CK,
		ST_POP,
		ST_POPD,
		ST_NBR,
		ST_DRAIN,
		ST_NEXT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic in_take;
		logic fg_wr;
		logic lab_rd;
		logic reg_rd;
		logic clr_step;
		logic run_init;
		logic scan_rd;
		logic scan_next;
		logic seed;
		logic pop;
		logic pop_load;
		logic nbr_issue;
		logic nbr_check;
		logic rec_store;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic clr_done;
		logic scan_done;
		logic seed_hit;
		logic stack_empty;
		logic nbr_last;
		logic out_free;
	} stat_t;

endpackage

>>> sv/ccl_ctrl.sv
module ccl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ccl_pkg::stat_t stat,
	output ccl_pkg::cmd_t  cmd
);

	ccl_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccl_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccl_pkg::ST_INIT: begin
				if (stat.clr_done) state_d = ccl_pkg::ST_IDLE;
			end
			ccl_pkg::ST_IDLE: begin
				if (in_valid) state_d = ccl_pkg::ST_EXEC;
			end
			ccl_pkg::ST_EXEC: begin
				unique case (stat.op)
					ccl_pkg::OP_LOAD:   state_d = ccl_pkg::ST_RESP;
					ccl_pkg::OP_RUN:    state_d = ccl_pkg::ST_CLR;
					ccl_pkg::OP_LABEL:  state_d = ccl_pkg::ST_RWAIT;
					ccl_pkg::OP_REGION: state_d = ccl_pkg::ST_RWAIT;
					default:            state_d = ccl_pkg::ST_RESP;
				endcase
			end
			ccl_pkg::ST_RWAIT: state_d = ccl_pkg::ST_RESP;
			ccl_pkg::ST_CLR: begin
				if (stat.clr_done) state_d = ccl_pkg::ST_SCAN_RD;
			end
			ccl_pkg::ST_SCAN_RD: begin
				state_d = stat.scan_done ? ccl_pkg::ST_RESP : ccl_pkg::ST_SCAN_CK;
			end
			ccl_pkg::ST_SCAN_CK: begin
				state_d = stat.seed_hit ? ccl_pkg::ST_POP : ccl_pkg::ST_SCAN_RD;
			end
			ccl_pkg::ST_POP:   state_d = ccl_pkg::ST_POPD;
			ccl_pkg::ST_POPD:  state_d = ccl_pkg::ST_NBR;
			ccl_pkg::ST_NBR: begin
				if (stat.nbr_last) state_d = ccl_pkg::ST_DRAIN;
			end
			ccl_pkg::ST_DRAIN: state_d = ccl_pkg::ST_NEXT;
			ccl_pkg::ST_NEXT: begin
				state_d = stat.stack_empty ? ccl_pkg::ST_SCAN_RD : ccl_pkg::ST_POP;
			end
			ccl_pkg::ST_RESP: begin
				if (stat.out_free) state_d = ccl_pkg::ST_IDLE;
			end
			default: state_d = ccl_pkg::ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ccl_pkg::ST_INIT: cmd.clr_step = 1'b1;
			ccl_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.in_take = in_valid;
			end
			ccl_pkg::ST_EXEC: begin
				unique case (stat.op)
					ccl_pkg::OP_LOAD:   cmd.fg_wr    = 1'b1;
					ccl_pkg::OP_RUN:    cmd.run_init = 1'b1;
					ccl_pkg::OP_LABEL:  cmd.lab_rd   = 1'b1;
					ccl_pkg::OP_REGION: cmd.reg_rd   = 1'b1;
					default:            cmd.fg_wr    = 1'b0;
				endcase
			end
			ccl_pkg::ST_RWAIT:   cmd = '0;
			ccl_pkg::ST_CLR:     cmd.clr_step = 1'b1;
			ccl_pkg::ST_SCAN_RD: cmd.scan_rd = !stat.scan_done;
			ccl_pkg::ST_SCAN_CK: begin
				cmd.seed      = stat.seed_hit;
				cmd.scan_next = !stat.seed_hit;
			end
			ccl_pkg::ST_POP:  cmd.pop = 1'b1;
			ccl_pkg::ST_POPD: cmd.pop_load = 1'b1;
			ccl_pkg::ST_NBR: begin
				cmd.nbr_issue = 1'b1;
				cmd.nbr_check = 1'b1;
			end
			ccl_pkg::ST_DRAIN: cmd.nbr_check = 1'b1;
			ccl_pkg::ST_NEXT: begin
				cmd.rec_store = stat.stack_empty;
				cmd.scan_next = stat.stack_empty;
			end
			ccl_pkg::ST_RESP: cmd.out_load = stat.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> sv/ccl_dp.sv
module ccl_dp #(
	parameter int MAX_SIDE    = 256,
	parameter int MAX_REGIONS = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ccl_pkg::cmd_t                       cmd,
	output ccl_pkg::stat_t                      stat,
	input  logic                                cfg_write_en,
	input  logic [ccl_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [ccl_pkg::CFG_W-1:0]           cfg_data,
	input  logic [ccl_pkg::OP_W-1:0]            opcode,
	input  logic [ccl_pkg::PIX_W-1:0]           pixel_index,
	input  logic [ccl_pkg::VAL_W-1:0]           pixel_value,
	input  logic [ccl_pkg::REG_W-1:0]           region_index,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                status,
	output logic [ccl_pkg::CNT_W-1:0]           region_count,
	output logic [ccl_pkg::CNT_W-1:0]           pixel_label,
	output logic [ccl_pkg::COORD_W-1:0]         row_min,
	output logic [ccl_pkg::COORD_W-1:0]         col_min,
	output logic [ccl_pkg::COORD_W-1:0]         row_max,
	output logic [ccl_pkg::COORD_W-1:0]         col_max,
	output logic [ccl_pkg::AREA_W-1:0]          area
);

	localparam int SW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int EW   = SW + 1;
	localparam int AW   = 2 * SW;
	localparam int ARW  = AW + 1;
	localparam int NPIX = MAX_SIDE * MAX_SIDE;
	localparam int LW   = $clog2(MAX_REGIONS + 1);
	localparam int RAW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int SEW  = 2 * SW + AW;
	localparam int TW   = 4 * SW + ARW;

	logic [ccl_pkg::CFG_W-1:0] rows_q, cols_q;
	logic [EW-1:0]             rows_eff, cols_eff;
	logic [2*EW-1:0]           npix_q;

	ccl_pkg::op_t              op_q;
	logic [ccl_pkg::PIX_W-1:0] pix_q;
	logic [ccl_pkg::VAL_W-1:0] val_q;
	logic [ccl_pkg::REG_W-1:0] reg_q;
	logic                      pix_ok, reg_ok;

	logic [LW-1:0]  count_q, lab_new;
	logic [AW-1:0]  clr_cnt_q;
	logic           clr_done;

	logic [EW-1:0]  sr_q;
	logic [SW-1:0]  sc_q;
	logic [ARW-1:0] sp_q;

	logic [ARW-1:0] top_q, top_m1;
	logic [SEW-1:0] st_rd_q, push_data;
	logic [SW-1:0]  st_r, st_c;
	logic [AW-1:0]  st_p;

	logic [SW-1:0]  cur_r_q, cur_c_q;
	logic [AW-1:0]  cur_p_q;
	logic [2:0]     k_q;
	logic           up, dn, lf, rt, inb;
	logic [EW-1:0]  nr, nc;
	logic [AW+1:0]  q_sum;
	logic           pend_v_q;
	logic [SW-1:0]  pend_r_q, pend_c_q;
	logic [AW-1:0]  pend_p_q;
	logic           push_nbr;

	logic [SW-1:0]  rmin_q, rmax_q, cmin_q, cmax_q;
	logic [ARW-1:0] area_q;

	logic [AW-1:0]  rd_addr;
	logic           rd_en;
	logic [LW-1:0]  lab_rd_q;
	logic           fg_rd_q;
	logic [TW-1:0]  tab_rd_q;
	logic           out_valid_q;

	logic [LW-1:0]  lab_mem [NPIX];
	logic           fg_mem  [NPIX];
	logic [SEW-1:0] stk_mem [NPIX];
	logic [TW-1:0]  tab_mem [MAX_REGIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ccl_pkg::CFG_W'(256);
			cols_q <= ccl_pkg::CFG_W'(256);
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				ccl_pkg::REG_ROWS: rows_q <= cfg_data;
				ccl_pkg::REG_COLS: cols_q <= cfg_data;
				default:           rows_q <= rows_q;
			endcase
		end
	end

	assign rows_eff = (32'(rows_q) > 32'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(rows_q);
	assign cols_eff = (32'(cols_q) > 32'(MAX_SIDE)) ? EW'(MAX_SIDE) : EW'(cols_q);

	always_ff @(posedge clk) begin
		npix_q <= (2*EW)'(rows_eff) * (2*EW)'(cols_eff);
		if (cmd.in_take) begin
			op_q  <= ccl_pkg::op_t'(opcode);
			pix_q <= pixel_index;
			val_q <= pixel_value;
			reg_q <= region_index;
		end
	end

	assign pix_ok  = 32'(pix_q) < 32'(npix_q);
	assign reg_ok  = 32'(reg_q) < 32'(count_q);
	assign lab_new = count_q + LW'(1);
	assign clr_done = clr_cnt_q == AW'(NPIX - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			count_q   <= '0;
			sr_q      <= '0;
			sc_q      <= '0;
			sp_q      <= '0;
			top_q     <= '0;
			k_q       <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_cnt_q <= clr_done ? '0 : clr_cnt_q + AW'(1);
			if (cmd.run_init) begin
				count_q <= '0;
				sr_q    <= '0;
				sc_q    <= '0;
				sp_q    <= '0;
				top_q   <= '0;
			end
			if (cmd.rec_store) count_q <= lab_new;
			if (cmd.scan_next) begin
				if (EW'(sc_q) + EW'(1) == cols_eff) begin
					sc_q <= '0;
					sr_q <= sr_q + EW'(1);
				end else begin
					sc_q <= sc_q + SW'(1);
				end
				sp_q <= sp_q + ARW'(1);
			end
			if (cmd.seed || push_nbr) top_q <= top_q + ARW'(1);
			else if (cmd.pop) top_q <= top_m1;
			if (cmd.pop_load) k_q <= '0;
			else if (cmd.nbr_issue) k_q <= k_q + 3'd1;
			if (cmd.nbr_issue) pend_v_q <= inb;
			else if (cmd.pop_load) pend_v_q <= 1'b0;
		end
	end

	assign top_m1 = top_q - ARW'(1);
	assign {st_r, st_c, st_p} = st_rd_q;

	always_comb begin
		up = 1'b0;
		dn = 1'b0;
		lf = 1'b0;
		rt = 1'b0;
		case (k_q)
			3'd0: begin up = 1'b1; lf = 1'b1; end
			3'd1: up = 1'b1;
			3'd2: begin up = 1'b1; rt = 1'b1; end
			3'd3: lf = 1'b1;
			3'd4: rt = 1'b1;
			3'd5: begin dn = 1'b1; lf = 1'b1; end
			3'd6: dn = 1'b1;
			default: begin dn = 1'b1; rt = 1'b1; end
		endcase
	end

	assign nr = up ? EW'(cur_r_q) - EW'(1) : (dn ? EW'(cur_r_q) + EW'(1) : EW'(cur_r_q));
	assign nc = lf ? EW'(cur_c_q) - EW'(1) : (rt ? EW'(cur_c_q) + EW'(1) : EW'(cur_c_q));
	assign inb = !(up && cur_r_q == '0) && !(lf && cur_c_q == '0)
		&& (nr < rows_eff) && (nc < cols_eff);
	assign q_sum = (AW+2)'(cur_p_q) + (dn ? (AW+2)'(cols_eff) : '0)
		- (up ? (AW+2)'(cols_eff) : '0) + (rt ? (AW+2)'(1) : '0) - (lf ? (AW+2)'(1) : '0);

	assign push_nbr = cmd.nbr_check && pend_v_q && fg_rd_q && (lab_rd_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.nbr_issue) begin
			pend_r_q <= nr[SW-1:0];
			pend_c_q <= nc[SW-1:0];
			pend_p_q <= q_sum[AW-1:0];
		end
		if (cmd.pop_load) begin
			cur_r_q <= st_r;
			cur_c_q <= st_c;
			cur_p_q <= st_p;
			area_q  <= area_q + ARW'(1);
			if (st_r < rmin_q) rmin_q <= st_r;
			if (st_r > rmax_q) rmax_q <= st_r;
			if (st_c < cmin_q) cmin_q <= st_c;
			if (st_c > cmax_q) cmax_q <= st_c;
		end
		if (cmd.seed) begin
			rmin_q <= sr_q[SW-1:0];
			rmax_q <= sr_q[SW-1:0];
			cmin_q <= sc_q;
			cmax_q <= sc_q;
			area_q <= '0;
		end
	end

	assign rd_addr = cmd.lab_rd ? AW'(pix_q) : (cmd.scan_rd ? sp_q[AW-1:0] : q_sum[AW-1:0]);
	assign rd_en   = cmd.lab_rd || cmd.scan_rd || cmd.nbr_issue;
	assign push_data = cmd.seed ? {sr_q[SW-1:0], sc_q, sp_q[AW-1:0]}
		: {pend_r_q, pend_c_q, pend_p_q};

	always_ff @(posedge clk) begin
		if (rd_en) begin
			lab_rd_q <= lab_mem[rd_addr];
			fg_rd_q  <= fg_mem[rd_addr];
		end
		if (cmd.clr_step) lab_mem[clr_cnt_q] <= '0;
		else if (cmd.seed) lab_mem[sp_q[AW-1:0]] <= lab_new;
		else if (push_nbr) lab_mem[pend_p_q] <= lab_new;
		if (cmd.fg_wr && pix_ok) fg_mem[AW'(pix_q)] <= (val_q == '0);
		if (cmd.seed || push_nbr) stk_mem[top_q[AW-1:0]] <= push_data;
		if (cmd.pop) st_rd_q <= stk_mem[top_m1[AW-1:0]];
		if (cmd.rec_store) tab_mem[count_q[RAW-1:0]] <= {rmin_q, cmin_q, rmax_q, cmax_q, area_q};
		if (cmd.reg_rd) tab_rd_q <= tab_mem[RAW'(reg_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			region_count <= ccl_pkg::CNT_W'(count_q);
			status       <= 1'b0;
			pixel_label  <= '0;
			row_min      <= '0;
			col_min      <= '0;
			row_max      <= '0;
			col_max      <= '0;
			area         <= '0;
			case (op_q)
				ccl_pkg::OP_LOAD: status <= !pix_ok;
				ccl_pkg::OP_LABEL: begin
					status <= !pix_ok;
					if (pix_ok) pixel_label <= ccl_pkg::CNT_W'(lab_rd_q);
				end
				ccl_pkg::OP_REGION: begin
					status <= !reg_ok;
					if (reg_ok) begin
						row_min <= ccl_pkg::COORD_W'(tab_rd_q[TW-1 -: SW]);
						col_min <= ccl_pkg::COORD_W'(tab_rd_q[TW-SW-1 -: SW]);
						row_max <= ccl_pkg::COORD_W'(tab_rd_q[TW-2*SW-1 -: SW]);
						col_max <= ccl_pkg::COORD_W'(tab_rd_q[TW-3*SW-1 -: SW]);
						area    <= ccl_pkg::AREA_W'(tab_rd_q[ARW-1:0]);
					end
				end
				default: status <= 1'b0;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	assign stat.op          = op_q;
	assign stat.clr_done    = clr_done;
	assign stat.scan_done   = (sr_q == rows_eff) || (cols_eff == '0)
		|| (32'(count_q) == 32'(MAX_REGIONS));
	assign stat.seed_hit    = fg_rd_q && (lab_rd_q == '0);
	assign stat.stack_empty = top_q == '0;
	assign stat.nbr_last    = k_q == 3'd7;
	assign stat.out_free    = !out_valid_q || !out_stall;

endmodule

>>> sv/connected_component_labeler.sv
// Labels the 8-connected foreground regions of a binary image of up to
// MAX_SIDE by MAX_SIDE pixels; a pixel byte of zero is foreground.
// The input channel carries one command item: load a pixel, run labeling,
// read a pixel's label, or read a region's bounding box and area. Every
// item gives exactly one result item on the output channel.
// The user writes the image size registers through the configuration
// port only while the block is idle; the block does not enforce this.
// A load gives its result once the pixel is written, a label or region
// read once its memory read is done. A run first clears the label memory,
// one entry per cycle over all MAX_SIDE*MAX_SIDE entries, then scans the
// image pixel by pixel, reading and then checking each one, and floods
// from each unlabeled foreground pixel, checking the 8 neighbors of each
// popped pixel through one read port of the label and image memories.
// Only one item is worked on at a time; the next is accepted once the
// result has been written to the output register, even while that result
// is still stalled.
// After reset the block clears all MAX_SIDE*MAX_SIDE label memory entries
// with in_stall high, and both size registers hold 256.
// While out_stall is high the result stays unchanged on the output ports.
module connected_component_labeler #(
	parameter int MAX_SIDE    = 256,
	parameter int MAX_REGIONS = 16384
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [ccl_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [ccl_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ccl_pkg::OP_W-1:0]    opcode,
	input  logic [ccl_pkg::PIX_W-1:0]   pixel_index,
	input  logic [ccl_pkg::VAL_W-1:0]   pixel_value,
	input  logic [ccl_pkg::REG_W-1:0]   region_index,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic [ccl_pkg::CNT_W-1:0]   region_count,
	output logic [ccl_pkg::CNT_W-1:0]   pixel_label,
	output logic [ccl_pkg::COORD_W-1:0] row_min,
	output logic [ccl_pkg::COORD_W-1:0] col_min,
	output logic [ccl_pkg::COORD_W-1:0] row_max,
	output logic [ccl_pkg::COORD_W-1:0] col_max,
	output logic [ccl_pkg::AREA_W-1:0]  area
);

	ccl_pkg::cmd_t  cmd;
	ccl_pkg::stat_t stat;

	ccl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ccl_dp #(
		.MAX_SIDE    (MAX_SIDE),
		.MAX_REGIONS (MAX_REGIONS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.opcode       (opcode),
		.pixel_index  (pixel_index),
		.pixel_value  (pixel_value),
		.region_index (region_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.region_count (region_count),
		.pixel_label  (pixel_label),
		.row_min      (row_min),
		.col_min      (col_min),
		.row_max      (row_max),
		.col_max      (col_max),
		.area         (area)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

typedef struct packed {
	logic                         status;
	logic [ccl_pkg::CNT_W-1:0]    count;
	logic [ccl_pkg::CNT_W-1:0]    label;
	logic [ccl_pkg::COORD_W-1:0]  rmin;
	logic [ccl_pkg::COORD_W-1:0]  cmin;
	logic [ccl_pkg::COORD_W-1:0]  rmax;
	logic [ccl_pkg::COORD_W-1:0]  cmax;
	logic [ccl_pkg::AREA_W-1:0]   area;
} ccl_result_t;

class ccl_scoreboard;
	localparam int SIDE = 256;
	localparam int NPIX = SIDE * SIDE;
	localparam int REGIONS = 16384;

	bit                       fg[NPIX];
	bit [ccl_pkg::CNT_W-1:0]  labels[NPIX];
	int                       box_rmin[REGIONS];
	int                       box_cmin[REGIONS];
	int                       box_rmax[REGIONS];
	int                       box_cmax[REGIONS];
	int                       box_area[REGIONS];
	int                       found;
	int                       rows;
	int                       cols;
	int                       errors;
	ccl_result_t              expected_q[$];

	function new();
		found = 0;
		rows = SIDE;
		cols = SIDE;
		errors = 0;
	endfunction

	function int clip(int v);
		return (v > SIDE) ? SIDE : v;
	endfunction

	function int pixels();
		return clip(rows) * clip(cols);
	endfunction

	function void write_reg(logic [ccl_pkg::CIDX_W-1:0] idx, int v);
		if (idx == ccl_pkg::REG_ROWS) begin
			rows = v;
		end else begin
			cols = v;
		end
	endfunction

	function void flood(int seed, int r_n, int c_n, int lab, int slot);
		int stack[$];
		int p, r, c, nr, nc, q;
		labels[seed] = ccl_pkg::CNT_W'(lab);
		stack.push_back(seed);
		box_rmin[slot] = seed / c_n;
		box_rmax[slot] = seed / c_n;
		box_cmin[slot] = seed % c_n;
		box_cmax[slot] = seed % c_n;
		box_area[slot] = 0;
		while (stack.size() > 0) begin
			p = stack.pop_back();
			r = p / c_n;
			c = p % c_n;
			box_area[slot]++;
			if (r < box_rmin[slot]) box_rmin[slot] = r;
			if (r > box_rmax[slot]) box_rmax[slot] = r;
			if (c < box_cmin[slot]) box_cmin[slot] = c;
			if (c > box_cmax[slot]) box_cmax[slot] = c;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					nr = r + dr;
					nc = c + dc;
					if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < r_n && nc < c_n) begin
						q = nr * c_n + nc;
						if (fg[q] && labels[q] == '0) begin
							labels[q] = ccl_pkg::CNT_W'(lab);
							stack.push_back(q);
						end
					end
				end
			end
		end
	endfunction

	function void label_image();
		int r_n, c_n;
		r_n = clip(rows);
		c_n = clip(cols);
		for (int p = 0; p < NPIX; p++) labels[p] = '0;
		found = 0;
		for (int p = 0; p < r_n * c_n; p++) begin
			if (fg[p] && labels[p] == '0 && found < REGIONS) begin
				flood(p, r_n, c_n, found + 1, found);
				found++;
			end
		end
	endfunction

	function void note(ccl_pkg::op_t op, int pix, int val, int rg);
		ccl_result_t e;
		e = '0;
		case (op)
			ccl_pkg::OP_LOAD: begin
				if (pix < pixels()) fg[pix] = (val == 0);
				else e.status = 1'b1;
			end
			ccl_pkg::OP_RUN: begin
				label_image();
			end
			ccl_pkg::OP_LABEL: begin
				if (pix < pixels()) e.label = labels[pix];
				else e.status = 1'b1;
			end
			default: begin
				if (rg < found) begin
					e.rmin = ccl_pkg::COORD_W'(box_rmin[rg]);
					e.cmin = ccl_pkg::COORD_W'(box_cmin[rg]);
					e.rmax = ccl_pkg::COORD_W'(box_rmax[rg]);
					e.cmax = ccl_pkg::COORD_W'(box_cmax[rg]);
					e.area = ccl_pkg::AREA_W'(box_area[rg]);
				end else begin
					e.status = 1'b1;
				end
			end
		endcase
		e.count = ccl_pkg::CNT_W'(found);
		expected_q.push_back(e);
	endfunction

	function void compare(string name, int e, int a);
		if (e != a) begin
			$error("%s mismatch: expected %0d, got %0d", name, e, a);
			errors++;
		end
	endfunction

	function void check(ccl_result_t got);
		ccl_result_t e;
		if (expected_q.size() == 0) begin
			$error("result item with no expectation waiting");
			errors++;
			return;
		end
		e = expected_q.pop_front();
		compare("status", int'(e.status), int'(got.status));
		compare("region_count", int'(e.count), int'(got.count));
		compare("pixel_label", int'(e.label), int'(got.label));
		compare("row_min", int'(e.rmin), int'(got.rmin));
		compare("col_min", int'(e.cmin), int'(got.cmin));
		compare("row_max", int'(e.rmax), int'(got.rmax));
		compare("col_max", int'(e.cmax), int'(got.cmax));
		compare("area", int'(e.area), int'(got.area));
	endfunction
endclass

module testbench;
	localparam int LIMIT = 3000000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_write_en;
	logic [ccl_pkg::CIDX_W-1:0]   cfg_index;
	logic [ccl_pkg::CFG_W-1:0]    cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [ccl_pkg::OP_W-1:0]     opcode;
	logic [ccl_pkg::PIX_W-1:0]    pixel_index;
	logic [ccl_pkg::VAL_W-1:0]    pixel_value;
	logic [ccl_pkg::REG_W-1:0]    region_index;
	logic                         out_valid;
	logic                         out_stall;
	logic                         status;
	logic [ccl_pkg::CNT_W-1:0]    region_count;
	logic [ccl_pkg::CNT_W-1:0]    pixel_label;
	logic [ccl_pkg::COORD_W-1:0]  row_min;
	logic [ccl_pkg::COORD_W-1:0]  col_min;
	logic [ccl_pkg::COORD_W-1:0]  row_max;
	logic [ccl_pkg::COORD_W-1:0]  col_max;
	logic [ccl_pkg::AREA_W-1:0]   area;

	ccl_scoreboard sb;
	int send_idle;
	int recv_stall;
	int cycles;

	connected_component_labeler DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .pixel_index(pixel_index), .pixel_value(pixel_value),
		.region_index(region_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .region_count(region_count), .pixel_label(pixel_label),
		.row_min(row_min), .col_min(col_min), .row_max(row_max), .col_max(col_max),
		.area(area)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
			if (in_valid && !in_stall) begin
				sb.note(ccl_pkg::op_t'(opcode), int'(pixel_index), int'(pixel_value),
					int'(region_index));
			end
			if (out_valid && !out_stall) begin
				sb.check({status, region_count, pixel_label, row_min, col_min,
					row_max, col_max, area});
			end
		end
	end

	task automatic send(ccl_pkg::op_t op, int pix, int val, int rg);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pixel_index <= ccl_pkg::PIX_W'(pix);
		pixel_value <= ccl_pkg::VAL_W'(val);
		region_index <= ccl_pkg::REG_W'(rg);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0 || in_stall) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(logic [ccl_pkg::CIDX_W-1:0] idx, int v);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= ccl_pkg::CFG_W'(v);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.write_reg(idx, v);
	endtask

	task automatic set_size(int r, int c);
		wait_idle();
		write_reg(ccl_pkg::REG_ROWS, r);
		write_reg(ccl_pkg::REG_COLS, c);
	endtask

	task automatic random_query(int n);
		int sel;
		int pix;
		sel = $urandom_range(2);
		pix = (n > 0 && $urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(65535, n);
		if (sel == 0) begin
			send(ccl_pkg::OP_LOAD, pix, ($urandom_range(1) == 0) ? 0 : $urandom_range(255, 1),
				$urandom_range(16383));
		end else if (sel == 1) begin
			send(ccl_pkg::OP_LABEL, pix, $urandom_range(255), $urandom_range(16383));
		end else begin
			send(ccl_pkg::OP_REGION, $urandom_range(65535), $urandom_range(255),
				($urandom_range(15) == 0) ? 16383 : $urandom_range(sb.found + 1));
		end
	endtask

	task automatic run_phase(int r, int c, int runs);
		int n;
		int density;
		set_size(r, c);
		n = sb.pixels();
		density = $urandom_range(60, 20);
		for (int i = 0; i < n; i++) begin
			send(ccl_pkg::OP_LOAD, i, ($urandom_range(99) < density) ? 0 : $urandom_range(255, 1),
				$urandom_range(16383));
		end
		repeat (8) random_query(n);
		for (int k = 0; k < runs; k++) begin
			wait_idle();
			send(ccl_pkg::OP_RUN, $urandom_range(65535), $urandom_range(255),
				$urandom_range(16383));
			repeat (n / 8 + 10) random_query(n);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = '0;
		pixel_index = '0;
		pixel_value = '0;
		region_index = '0;
		send_idle = 28;
		recv_stall = 69;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(ccl_pkg::OP_LABEL, 65535, 0, 0);
		send(ccl_pkg::OP_REGION, 0, 0, 0);
		send(ccl_pkg::OP_REGION, 0, 0, 16383);
		set_size(3, 4);
		// A diagonal chain of three pixels and two lone corner pixels.
		send(ccl_pkg::OP_LOAD, 0, 0, 0);
		send(ccl_pkg::OP_LOAD, 1, 255, 0);
		send(ccl_pkg::OP_LOAD, 2, 1, 0);
		send(ccl_pkg::OP_LOAD, 3, 0, 0);
		send(ccl_pkg::OP_LOAD, 4, 128, 0);
		send(ccl_pkg::OP_LOAD, 5, 0, 0);
		send(ccl_pkg::OP_LOAD, 6, 7, 0);
		send(ccl_pkg::OP_LOAD, 7, 200, 0);
		send(ccl_pkg::OP_LOAD, 8, 0, 0);
		send(ccl_pkg::OP_LOAD, 9, 255, 0);
		send(ccl_pkg::OP_LOAD, 10, 255, 0);
		send(ccl_pkg::OP_LOAD, 11, 0, 0);
		send(ccl_pkg::OP_LOAD, 12, 0, 0);
		send(ccl_pkg::OP_LOAD, 65535, 0, 0);
		wait_idle();
		send(ccl_pkg::OP_RUN, 0, 0, 0);
		send(ccl_pkg::OP_LABEL, 5, 0, 0);
		send(ccl_pkg::OP_LABEL, 11, 0, 0);
		send(ccl_pkg::OP_LABEL, 1, 0, 0);
		send(ccl_pkg::OP_LABEL, 12, 0, 0);
		send(ccl_pkg::OP_REGION, 0, 0, 0);
		send(ccl_pkg::OP_REGION, 0, 0, 2);
		send(ccl_pkg::OP_REGION, 0, 0, 3);

		run_phase(0, 5, 1);
		run_phase(8, 8, 2);
		send_idle = 69;
		recv_stall = 28;
		run_phase(1, 40, 1);
		send_idle = 0;
		recv_stall = 0;
		run_phase(6, 9, 1);
		run_phase(2, 2, 1);
		run_phase(5, 7, 1);

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule

>>> files.f
sv/ccl_pkg.sv
sv/ccl_ctrl.sv
sv/ccl_dp.sv
sv/connected_component_labeler.sv
tb/testbench.sv
